// ===== sv/lcp3_pkg.sv =====
package lcp3_pkg;

    localparam int PT_W   = 32;
    localparam int DIR_W  = 16;
    localparam int NN_W   = 64;
    localparam int NUM_W  = 83;
    localparam int PROD_W = 99;
    localparam int Q_W    = 35;
    localparam int QM_W   = 34;
    localparam logic [QM_W-1:0] OFF_LIMIT = QM_W'(1) << 33;

    typedef struct packed {
        logic signed [PT_W-1:0]  p1_x;
        logic signed [PT_W-1:0]  p1_y;
        logic signed [PT_W-1:0]  p1_z;
        logic signed [DIR_W-1:0] d1_x;
        logic signed [DIR_W-1:0] d1_y;
        logic signed [DIR_W-1:0] d1_z;
        logic signed [PT_W-1:0]  p2_x;
        logic signed [PT_W-1:0]  p2_y;
        logic signed [PT_W-1:0]  p2_z;
        logic signed [DIR_W-1:0] d2_x;
        logic signed [DIR_W-1:0] d2_y;
        logic signed [DIR_W-1:0] d2_z;
    } lcp3_in_t;

    typedef struct packed {
        logic signed [PT_W-1:0] closest_x;
        logic signed [PT_W-1:0] closest_y;
        logic signed [PT_W-1:0] closest_z;
        logic                   parallel_flag;
    } lcp3_out_t;

    // One axis worth of work handed from the front end to a divider lane
    typedef struct packed {
        logic                   vld;
        logic                   par;
        logic                   neg;
        logic [NUM_W-1:0]       num_mag;
        logic [NN_W-1:0]        nn;
        logic [DIR_W-1:0]       dmag;
        logic                   dneg;
        logic signed [PT_W-1:0] p1;
    } lcp3_axis_t;

    typedef struct packed {
        logic                   vld;
        logic                   par;
        logic signed [PT_W-1:0] coord;
    } lcp3_res_t;

    // Cyclic neighbors of an axis index
    function automatic int nx1(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic int nx2(input int i);
        return (i == 0) ? 2 : i - 1;
    endfunction

endpackage

// ===== sv/lcp3_front.sv =====
module lcp3_front import lcp3_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_vld,
    input  lcp3_in_t   in_data,
    output lcp3_axis_t axis [3]
);

    logic signed [PT_W-1:0]  p1 [3];
    logic signed [PT_W-1:0]  p2 [3];
    logic signed [DIR_W-1:0] d1 [3];
    logic signed [DIR_W-1:0] d2 [3];

    assign p1[0] = in_data.p1_x;
    assign p1[1] = in_data.p1_y;
    assign p1[2] = in_data.p1_z;
    assign p2[0] = in_data.p2_x;
    assign p2[1] = in_data.p2_y;
    assign p2[2] = in_data.p2_z;
    assign d1[0] = in_data.d1_x;
    assign d1[1] = in_data.d1_y;
    assign d1[2] = in_data.d1_z;
    assign d2[0] = in_data.d2_x;
    assign d2[1] = in_data.d2_y;
    assign d2[2] = in_data.d2_z;

    logic [8:1] v_reg;

    // payload per stage
    logic signed [31:0]       pa1_reg [3], pb1_reg [3];
    logic signed [32:0]       dp1_reg [3], dp2_reg [3], dp3_reg [3], dp4_reg [3];
    logic signed [DIR_W-1:0]  d2_1_reg [3], d2_2_reg [3];
    logic signed [32:0]       n2_reg [3];
    logic [NN_W-1:0]          sq3_reg [3];
    logic signed [48:0]       wa3_reg [3], wb3_reg [3];
    logic [NN_W-1:0]          nn4_reg, nn5_reg, nn6_reg, nn7_reg, nn8_reg;
    logic signed [48:0]       w4_reg [3];
    logic [56:0]              plo5_reg [3], phi5_reg [3];
    logic                     sg5_reg [3];
    logic                     z5_reg, z6_reg, z7_reg, z8_reg;
    logic signed [81:0]       t6_reg [3];
    logic signed [83:0]       num7_reg;
    logic                     neg8_reg;
    logic [NUM_W-1:0]         mag8_reg;
    logic signed [DIR_W-1:0]  d1_reg [8:1][3];
    logic signed [PT_W-1:0]   p1_reg [8:1][3];

    logic signed [65:0] sq_full [3];
    logic [48:0]        wabs [3];
    logic [32:0]        dabs [3];
    logic [80:0]        pmag [3];
    logic signed [83:0] num_abs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_full[i] = n2_reg[i] * n2_reg[i];
            wabs[i]    = w4_reg[i][48] ? 49'(-w4_reg[i]) : 49'(w4_reg[i]);
            dabs[i]    = dp4_reg[i][32] ? 33'(-dp4_reg[i]) : 33'(dp4_reg[i]);
            pmag[i]    = (81'(phi5_reg[i]) << 24) + 81'(plo5_reg[i]);
        end
        num_abs = num7_reg[83] ? -num7_reg : num7_reg;
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[7:1], in_vld};
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // cross-product terms of d1 x d2, point difference
                pa1_reg[i]  <= d1[nx1(i)] * d2[nx2(i)];
                pb1_reg[i]  <= d1[nx2(i)] * d2[nx1(i)];
                dp1_reg[i]  <= 33'(p2[i]) - 33'(p1[i]);
                d2_1_reg[i] <= d2[i];
                // normal
                n2_reg[i]   <= 33'(pa1_reg[i]) - 33'(pb1_reg[i]);
                dp2_reg[i]  <= dp1_reg[i];
                d2_2_reg[i] <= d2_1_reg[i];
                // squares and d2 x n terms
                sq3_reg[i]  <= sq_full[i][NN_W-1:0];
                wa3_reg[i]  <= d2_2_reg[nx1(i)] * n2_reg[nx2(i)];
                wb3_reg[i]  <= d2_2_reg[nx2(i)] * n2_reg[nx1(i)];
                dp3_reg[i]  <= dp2_reg[i];
                // d2 x n
                w4_reg[i]   <= wa3_reg[i] - wb3_reg[i];
                dp4_reg[i]  <= dp3_reg[i];
                // split product |w| * |dp|
                plo5_reg[i] <= wabs[i][23:0] * dabs[i];
                phi5_reg[i] <= wabs[i][47:24] * dabs[i];
                sg5_reg[i]  <= w4_reg[i][48] ^ dp4_reg[i][32];
                // signed term
                t6_reg[i]   <= sg5_reg[i] ? -82'(pmag[i]) : 82'(pmag[i]);
            end
            nn4_reg  <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            nn5_reg  <= nn4_reg;
            z5_reg   <= (nn4_reg == '0);
            nn6_reg  <= nn5_reg;
            z6_reg   <= z5_reg;
            num7_reg <= 84'(t6_reg[0]) + 84'(t6_reg[1]) + 84'(t6_reg[2]);
            nn7_reg  <= nn6_reg;
            z7_reg   <= z6_reg;
            neg8_reg <= num7_reg[83];
            mag8_reg <= num_abs[NUM_W-1:0];
            nn8_reg  <= nn7_reg;
            z8_reg   <= z7_reg;
            d1_reg[1] <= d1;
            p1_reg[1] <= p1;
            for (int s = 2; s <= 8; s++) begin
                d1_reg[s] <= d1_reg[s-1];
                p1_reg[s] <= p1_reg[s-1];
            end
        end
    end

    // hand one request per axis to the divider lanes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            axis[i].vld     = v_reg[8];
            axis[i].par     = z8_reg;
            axis[i].neg     = neg8_reg;
            axis[i].num_mag = mag8_reg;
            axis[i].nn      = nn8_reg;
            axis[i].dneg    = d1_reg[8][i][DIR_W-1];
            axis[i].dmag    = d1_reg[8][i][DIR_W-1] ? DIR_W'(-d1_reg[8][i])
                                                     : DIR_W'(d1_reg[8][i]);
            axis[i].p1      = p1_reg[8][i];
        end
    end

endmodule

// ===== sv/lcp3_div.sv =====
module lcp3_div import lcp3_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  lcp3_axis_t ax,
    output lcp3_res_t  res
);

    typedef struct packed {
        logic                   par;
        logic                   neg;
        logic                   ovf;
        logic signed [PT_W-1:0] p1;
        logic [NN_W-1:0]        nn;
    } dside_t;

    logic               v1_reg, v2_reg, vr_reg, vo_reg;
    dside_t             s1_reg, s2_reg, sr_reg;
    logic [43:0]        pp0_reg, pp1_reg;
    logic [42:0]        pp2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QM_W-1:0]    qm_reg;
    lcp3_res_t          res_reg;

    // division stages, index 0 is the entry
    logic               vd_reg  [Q_W+1];
    dside_t             sd_reg  [Q_W+1];
    logic [NN_W-1:0]    rem_reg [Q_W+1];
    logic [Q_W-1:0]     lq_reg  [Q_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vd_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg <= ax.vld;
            v2_reg <= v1_reg;
            vd_reg[0] <= v2_reg;
        end
    end

    // scale |num| by |d1|, then set up the long division
    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg    <= ax.num_mag[27:0] * ax.dmag;
            pp1_reg    <= ax.num_mag[55:28] * ax.dmag;
            pp2_reg    <= ax.num_mag[82:56] * ax.dmag;
            s1_reg.par <= ax.par;
            s1_reg.neg <= ax.neg ^ ax.dneg;
            s1_reg.ovf <= 1'b0;
            s1_reg.p1  <= ax.p1;
            s1_reg.nn  <= ax.nn;
            prod_reg   <= PROD_W'(pp0_reg) + (PROD_W'(pp1_reg) << 28)
                          + (PROD_W'(pp2_reg) << 56);
            s2_reg     <= s1_reg;
            sd_reg[0].par  <= s2_reg.par;
            sd_reg[0].neg  <= s2_reg.neg;
            sd_reg[0].ovf  <= (prod_reg >= {s2_reg.nn, {Q_W{1'b0}}});
            sd_reg[0].p1   <= s2_reg.p1;
            sd_reg[0].nn   <= s2_reg.nn;
            rem_reg[0]     <= prod_reg[PROD_W-1:Q_W];
            lq_reg[0]      <= prod_reg[Q_W-1:0];
        end
    end

    // one quotient bit per stage, dividend bits shift out as quotient shifts in
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [NN_W:0] trial;
        logic          ge;

        assign trial = {rem_reg[k], lq_reg[k][Q_W-1]};
        assign ge    = (trial >= {1'b0, sd_reg[k].nn});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[k+1] <= 1'b0;
            end else if (en) begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[k+1]  <= sd_reg[k];
                rem_reg[k+1] <= ge ? NN_W'(trial - {1'b0, sd_reg[k].nn})
                                   : NN_W'(trial);
                lq_reg[k+1]  <= {lq_reg[k][Q_W-2:0], ge};
            end
        end
    end

    logic           up;
    logic [Q_W:0]   qr;
    logic signed [Q_W-1:0]  off;
    logic signed [PT_W+3:0] sum;
    logic signed [PT_W-1:0] sat;

    always_comb begin
        // round half away from zero on the magnitude
        up  = ({rem_reg[Q_W], 1'b0} >= {1'b0, sd_reg[Q_W].nn});
        qr  = (Q_W+1)'(lq_reg[Q_W]) + (Q_W+1)'(up);
        // apply sign, add to the point, clamp
        off = sr_reg.neg ? -$signed({1'b0, qm_reg}) : $signed({1'b0, qm_reg});
        sum = (PT_W+4)'(sr_reg.p1) + (PT_W+4)'(off);
        priority if (sum > (PT_W+4)'(2147483647)) begin
            sat = 32'sh7fff_ffff;
        end else if (sum < -(PT_W+4)'(64'sd2147483648)) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[PT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            vr_reg <= vd_reg[Q_W];
            vo_reg <= vr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg <= sd_reg[Q_W];
            qm_reg <= (sd_reg[Q_W].ovf || qr > (Q_W+1)'(OFF_LIMIT)) ? OFF_LIMIT
                                                                    : qr[QM_W-1:0];
            res_reg.vld   <= 1'b0;
            res_reg.par   <= sr_reg.par;
            res_reg.coord <= sr_reg.par ? sr_reg.p1 : sat;
        end
    end

    always_comb begin
        res       = res_reg;
        res.vld   = vo_reg;
    end

endmodule

// ===== sv/line_closest_point_3d.sv =====
// Closest point on line 1 to line 2. Each request carries two lines (Q16.16
// points, Q1.14 directions); the block returns p1 + t1*d1 with
// t1 = ((d2 x n).(p2 - p1)) / |n|^2, n = d1 x d2, rounded to nearest (ties
// away from zero) and saturated to the 32-bit point range. When |n|^2 is zero
// the flag is set and p1 comes back unchanged. The pipeline takes one request
// every cycle unless the result side stalls: 8 stages form the normal and
// the numerator, and each axis then runs a 40-stage lane built around its
// 35 restoring-division steps, one quotient bit per stage. A stall on
// the result side holds the whole pipeline in place.
module line_closest_point_3d import lcp3_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lcp3_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lcp3_out_t m_data
);

    logic       en;
    lcp3_axis_t axis [3];
    lcp3_res_t  res  [3];

    // advance everything unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    lcp3_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid),
        .in_data (s_data),
        .axis    (axis)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        lcp3_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ax      (axis[i]),
            .res     (res[i])
        );
    end

    assign m_valid              = res[0].vld;
    assign m_data.closest_x     = res[0].coord;
    assign m_data.closest_y     = res[1].coord;
    assign m_data.closest_z     = res[2].coord;
    assign m_data.parallel_flag = res[0].par;

    // lanes stay in lock step
    a_lane_vld: assert property (@(posedge aclk) disable iff (!aresetn)
        res[0].vld == res[1].vld && res[1].vld == res[2].vld)
        else $error("divider lanes out of step");

    a_lane_par: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (res[0].par == res[1].par && res[1].par == res[2].par))
        else $error("parallel flag differs across lanes");

    // a held result freezes the front end too
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(axis[0].num_mag) && $stable(axis[0].vld))
        else $error("front end moved during stall");

endmodule

// ===== sim/closest_point_checker.sv =====
`timescale 1ns / 1ps

module closest_point_checker import lcp3_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  lcp3_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  lcp3_out_t m_data,
    output int        fail_count,
    output int        pending_points
);

    lcp3_out_t expected_points[$];

    // Round-to-nearest magnitude division, ties away from zero
    function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = n / d;
        r = n % d;
        if (r >= ({64'd0, d} - r)) q = q + 1;
        return q;
    endfunction

    function automatic lcp3_out_t closest_point(input lcp3_in_t item);
        logic signed [63:0]  p1[3], p2[3], d1[3], d2[3], nrm[3], w[3];
        logic [63:0]         nn;
        logic signed [127:0] num;
        logic [127:0]        num_mag, prod, q;
        logic [63:0]         qm;
        logic signed [63:0]  off, sum;
        logic                num_neg;
        lcp3_out_t           res;
        p1[0] = item.p1_x; p1[1] = item.p1_y; p1[2] = item.p1_z;
        p2[0] = item.p2_x; p2[1] = item.p2_y; p2[2] = item.p2_z;
        d1[0] = item.d1_x; d1[1] = item.d1_y; d1[2] = item.d1_z;
        d2[0] = item.d2_x; d2[1] = item.d2_y; d2[2] = item.d2_z;
        // Common normal and its squared length
        nrm[0] = d1[1] * d2[2] - d1[2] * d2[1];
        nrm[1] = d1[2] * d2[0] - d1[0] * d2[2];
        nrm[2] = d1[0] * d2[1] - d1[1] * d2[0];
        nn = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
        res.parallel_flag = (nn == 0);
        if (nn == 0) begin
            res.closest_x = item.p1_x;
            res.closest_y = item.p1_y;
            res.closest_z = item.p1_z;
            return res;
        end
        w[0] = d2[1] * nrm[2] - d2[2] * nrm[1];
        w[1] = d2[2] * nrm[0] - d2[0] * nrm[2];
        w[2] = d2[0] * nrm[1] - d2[1] * nrm[0];
        num = 0;
        for (int i = 0; i < 3; i++)
            num = num + 128'(w[i]) * 128'(p2[i] - p1[i]);
        num_neg = num[127];
        num_mag = num_neg ? 128'(-num) : 128'(num);
        for (int i = 0; i < 3; i++) begin
            prod = num_mag * 128'(d1[i] < 0 ? -d1[i] : d1[i]);
            q = div_nearest(prod, nn);
            qm = (q > (128'd1 << 33)) ? (64'd1 << 33) : q[63:0];
            off = (num_neg != (d1[i] < 0)) ? -$signed(qm) : $signed(qm);
            sum = p1[i] + off;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            case (i)
                0: res.closest_x = sum[31:0];
                1: res.closest_y = sum[31:0];
                default: res.closest_z = sum[31:0];
            endcase
        end
        return res;
    endfunction

    assign pending_points = expected_points.size();

    // Predict on each request, compare on each result
    always @(posedge aclk) begin
        lcp3_out_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) expected_points.push_back(closest_point(s_data));
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench import lcp3_pkg::*;;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    lcp3_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    lcp3_out_t m_data;
    int        fail_count;
    int        pending_points;
    int        cycle_count = 0;
    int        sent_count = 0;
    logic      calm = 0;
    logic      hold_off = 0;

    line_closest_point_3d dut (.*);

    closest_point_checker checker_i (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off, and calm stretches
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_off && (calm || $urandom_range(99) >= 36);
    end

    initial begin
        wait (sent_count == 300);
        @(posedge aclk);
        hold_off <= 1;
        repeat (200) @(posedge aclk);
        hold_off <= 0;
    end

    function automatic logic signed [31:0] rand_point();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(65535)) - 32768) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return 16'sd16384;
            4: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic lcp3_in_t rand_lines();
        lcp3_in_t r;
        r.p1_x = rand_point(); r.p1_y = rand_point(); r.p1_z = rand_point();
        r.p2_x = rand_point(); r.p2_y = rand_point(); r.p2_z = rand_point();
        r.d1_x = rand_dir(); r.d1_y = rand_dir(); r.d1_z = rand_dir();
        r.d2_x = rand_dir(); r.d2_y = rand_dir(); r.d2_z = rand_dir();
        // Force parallel directions now and then
        if ($urandom_range(9) == 0) begin
            r.d2_x = r.d1_x; r.d2_y = r.d1_y; r.d2_z = r.d1_z;
        end
        return r;
    endfunction

    task automatic send_request(input lcp3_in_t item, input bit allow_idle);
        while (allow_idle && !calm && $urandom_range(99) < 36) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sent_count <= sent_count + 1;
    endtask

    initial begin
        lcp3_in_t item;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, zero and parallel directions, skew lines
        item = '0;
        send_request(item, 0);
        item = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000,
                 16'sh7fff, 16'sh0001};
        send_request(item, 0);
        item = '{0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 0, 0, 16384};
        send_request(item, 0);
        item = '{65536, 0, 0, 16384, 16384, 0, 0, 0, 0, 16384, 16384, 0};
        send_request(item, 0);
        item = '{32'sh7fff0000, 0, 0, 16384, 0, 0, 32'sh80000000, 0, 0, 1, 16384, 0};
        send_request(item, 0);
        item = '{32'sh80000000, 3, 5, 16'sh8000, 1, 0, 32'sh7fffffff, 7, 9, 0, 1, 16'sh8000};
        send_request(item, 0);
        item = '{1, 2, 3, 16'sh7fff, 16'sh7fff, 16'sh7fff, -1, -2, -3, 16'sh8000,
                 16'sh8000, 16'sh7fff};
        send_request(item, 0);
        item = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, 1, -1, 1};
        send_request(item, 0);
        for (int i = 0; i < 12; i++) send_request(rand_lines(), 0);

        // Random traffic; second half runs without sender idling for a while
        for (int i = 0; i < 630; i++) begin
            if (i == 400) begin
                s_valid <= 0;
                wait (pending_points == 0);
                @(posedge aclk);
            end
            calm <= (i >= 450 && i < 530);
            send_request(rand_lines(), 1);
        end
        s_valid <= 0;
        calm <= 0;

        wait (pending_points == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_points == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== line_closest_point_3d.f =====
sv/lcp3_pkg.sv
sv/lcp3_front.sv
sv/lcp3_div.sv
sv/line_closest_point_3d.sv
sim/closest_point_checker.sv
sim/testbench.sv
